// ===== hw/rtl/dirty_range_coalescer_defines.svh =====
`ifndef DIRTY_RANGE_COALESCER_DEFINES_SVH
`define DIRTY_RANGE_COALESCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DRC_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("drc assertion failed");

// next-cycle implication, checked outside reset
`define DRC_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("drc assertion failed");

// condition never holds
`define DRC_ASSERT_NEVER(lbl, clk, rst, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("drc assertion failed");

`endif

// ===== hw/rtl/drc_pkg.sv =====
`timescale 1ns / 1ps

package drc_pkg;

  localparam int ENTRY_COUNT_DEF = 1024;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int GAP_W           = 10;
  localparam int IN_TDATA_W      = 16;
  localparam int OUT_TDATA_W     = 24;
  localparam int OUT_PAD_W       = OUT_TDATA_W - IDX_W - CNT_W;
  localparam int IN_PAD_W        = IN_TDATA_W - IDX_W;

  localparam logic [GAP_W-1:0] GAP_MIN   = GAP_W'(20);
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(20);

  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_WALK  = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/dirty_range_coalescer.sv =====
`timescale 1ns / 1ps
// mark beat: no result; marks can follow every cycle while the output register is free
// flush beat with nothing dirty: one empty result in the output register next cycle
// flush beat with dirty entries: walks low_bound to high_bound, one entry per cycle
// through the single-port-read dirty memory, stalling while the result beat is held back
// reset: the dirty memory is swept clear, one entry per cycle,
// s_tready stays low meanwhile; gap_limit returns to 20 and can be written at once

`include "dirty_range_coalescer_defines.svh"

module dirty_range_coalescer
  import drc_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // entry_index, pad
  input  logic                   s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // range_start, range_count, pad
  output logic                   m_tuser,   // empty_res
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [GAP_W-1:0]       cfg_data
);

  localparam int AW = $clog2(ENTRY_COUNT);

  state_t state;

  logic [GAP_W-1:0] gap_limit;
  logic [IDX_W-1:0] low_bound;
  logic [IDX_W-1:0] high_bound;
  logic             any_dirty;

  logic [AW-1:0]    clr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_done;
  logic             proc_valid;
  logic [IDX_W-1:0] proc_addr;
  logic [CNT_W-1:0] skip;
  logic             open;
  logic [IDX_W-1:0] from;

  logic [IDX_W-1:0] range_start;
  logic [CNT_W-1:0] range_count;
  logic             empty_res;
  logic             last;

  logic             mem [ENTRY_COUNT];
  logic             mem_rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic             mem_wdata;
  logic             mem_re;

  logic             in_beat;
  logic             out_free;
  logic [IDX_W-1:0] entry_index;
  logic             mark_ok;
  logic [GAP_W-1:0] limit;
  logic [CNT_W-1:0] skip_inc;
  logic             open_n;
  logic [IDX_W-1:0] from_n;
  logic             proc_last;
  logic             emit;
  logic             step;
  logic             proc_step;
  logic             out_load;

  assign entry_index = s_tdata[IDX_W-1:0];
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == ST_IDLE) && out_free;
  assign in_beat     = s_tvalid && s_tready;
  assign cfg_ready   = 1'b1;
  assign mark_ok     = (32'(entry_index) < ENTRY_COUNT);

  assign limit     = (gap_limit < GAP_MIN) ? GAP_MIN : gap_limit;
  assign skip_inc  = skip + CNT_W'(!mem_rdata);
  assign open_n    = open || mem_rdata;
  assign from_n    = open ? from : proc_addr;
  assign proc_last = (proc_addr == high_bound);
  assign emit      = open_n && ((skip_inc >= {1'b0, limit}) || proc_last);
  assign step      = (state == ST_WALK) && (!proc_valid || !emit || out_free);
  assign proc_step = step && proc_valid;
  assign out_load  = (proc_step && emit) || (in_beat && s_tuser == FUNC_FLUSH && !any_dirty);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = in_beat && s_tuser == FUNC_MARK && mark_ok;
        mem_waddr = AW'(entry_index);
        mem_wdata = 1'b1;
      end
      ST_WALK: begin
        mem_we    = proc_step;
        mem_waddr = AW'(proc_addr);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re = step && !rd_done;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gap_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      low_bound  <= '0;
      high_bound <= '0;
      any_dirty  <= 1'b0;
      rd_addr    <= '0;
      rd_done    <= 1'b1;
      proc_valid <= 1'b0;
      proc_addr  <= '0;
      skip       <= '0;
      open       <= 1'b0;
      from       <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(ENTRY_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_beat) begin
            if (s_tuser == FUNC_MARK) begin
              if (mark_ok) begin
                if (!any_dirty || entry_index < low_bound) begin
                  low_bound <= entry_index;
                end
                if (!any_dirty || entry_index > high_bound) begin
                  high_bound <= entry_index;
                end
                any_dirty <= 1'b1;
              end
            end else if (any_dirty) begin
              state      <= ST_WALK;
              rd_addr    <= low_bound;
              rd_done    <= 1'b0;
              proc_valid <= 1'b0;
              skip       <= '0;
              open       <= 1'b0;
            end
          end
        end
        ST_WALK: begin
          // the last entry is processed with rd_done set, so proc_valid drops here
          if (step) begin
            proc_valid <= !rd_done;
            proc_addr  <= rd_addr;
            if (!rd_done) begin
              rd_addr <= rd_addr + IDX_W'(1);
              rd_done <= (rd_addr == high_bound);
            end
          end
          if (proc_step) begin
            skip <= emit ? '0 : skip_inc;
            open <= emit ? 1'b0 : open_n;
            from <= from_n;
            if (proc_last) begin
              state      <= ST_IDLE;
              low_bound  <= '0;
              high_bound <= '0;
              any_dirty  <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_WALK) begin
        range_start <= from_n;
        range_count <= {1'b0, proc_addr} + CNT_W'(1) - {1'b0, from_n};
        empty_res   <= 1'b0;
        last        <= proc_last;
      end else begin
        range_start <= '0;
        range_count <= '0;
        empty_res   <= 1'b1;
        last        <= 1'b1;
      end
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, range_count, range_start};
  assign m_tuser = empty_res;
  assign m_tlast = last;

  `DRC_ASSERT_NEVER(a_no_overwrite, clk, rst, out_load && m_tvalid && !m_tready)
  `DRC_ASSERT_NXT(a_last_ends_walk, clk, rst, proc_step && proc_last,
                  state == ST_IDLE && !any_dirty)
  `DRC_ASSERT_IMP(a_walk_in_span, clk, rst, state == ST_WALK && proc_valid,
                  proc_addr >= low_bound && proc_addr <= high_bound)
  `DRC_ASSERT_IMP(a_clear_clean, clk, rst, state == ST_CLEAR, !any_dirty && !m_tvalid)

endmodule

// ===== sim/dirty_range_coalescer_tb.sv =====
`timescale 1ns / 1ps

module dirty_range_coalescer_tb;
  import drc_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] idx;
  } beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             last;
  } range_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // entry_index, pad
  logic                   s_tuser = 1'b0; // func
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;        // range_start, range_count, pad
  logic                   m_tuser;        // empty_res
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [GAP_W-1:0]       cfg_data = '0;

  // shadow state of the coalescer
  bit               dirty_map [ENTRY_COUNT_DEF];
  logic [IDX_W-1:0] low_bound = '0;
  logic [IDX_W-1:0] high_bound = '0;
  bit               any_dirty = 1'b0;
  logic [GAP_W-1:0] gap_limit = GAP_RESET;

  beat_t  pending_beats[$];
  range_t expected_ranges[$];
  beat_t  next_beat;
  range_t seen_range;
  range_t want_range;
  bit     took_beat = 1'b0;
  bit     idle_on = 1'b0;
  int     send_gap = 0;
  int     ready_gap = 0;
  int     beats_queued = 0;
  int     fail_count = 0;
  int     cycle_count = 0;

  dirty_range_coalescer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic apply_beat(input beat_t b);
    int unsigned lim;
    int unsigned skip;
    int unsigned from;
    int unsigned i;
    int unsigned j;
    bit          open;
    range_t      r;
    range_t      found[$];
    if (b.func == FUNC_MARK) begin
      if (int'(b.idx) < ENTRY_COUNT_DEF) begin
        if (!any_dirty || b.idx < low_bound) low_bound = b.idx;
        if (!any_dirty || b.idx > high_bound) high_bound = b.idx;
        any_dirty = 1'b1;
        dirty_map[b.idx] = 1'b1;
      end
    end else if (!any_dirty) begin
      r = '{start: '0, count: '0, empty: 1'b1, last: 1'b1};
      expected_ranges.push_back(r);
    end else begin
      lim = (gap_limit < GAP_MIN) ? GAP_MIN : gap_limit;
      skip = 0;
      from = 0;
      open = 1'b0;
      for (i = low_bound; i <= high_bound; i++) begin
        if (!dirty_map[i]) begin
          skip++;
        end else if (!open) begin
          open = 1'b1;
          from = i;
        end
        if (open && (skip >= lim || i == high_bound)) begin
          for (j = from; j <= i; j++) dirty_map[j] = 1'b0;
          r.start = IDX_W'(from);
          r.count = CNT_W'(i + 1 - from);
          r.empty = 1'b0;
          r.last = 1'b0;
          found.push_back(r);
          skip = 0;
          open = 1'b0;
        end
      end
      if (found.size() == 0) begin
        r = '{start: '0, count: '0, empty: 1'b1, last: 1'b1};
        found.push_back(r);
      end else begin
        found[found.size() - 1].last = 1'b1;
      end
      foreach (found[k]) expected_ranges.push_back(found[k]);
      low_bound = '0;
      high_bound = '0;
      any_dirty = 1'b0;
    end
  endtask

  // beat acceptance, prediction and result checking
  always @(posedge clk) begin
    took_beat <= s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      seen_range = {m_tdata[IDX_W-1:0], m_tdata[IDX_W +: CNT_W], m_tuser, m_tlast};
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected result: start %0d count %0d empty %0b last %0b",
                 $time, seen_range.start, seen_range.count, seen_range.empty,
                 seen_range.last);
        fail_count++;
      end else begin
        want_range = expected_ranges.pop_front();
        if (seen_range !== want_range) begin
          $display("%0t: mismatch: expected start %0d count %0d empty %0b last %0b",
                   $time, want_range.start, want_range.count, want_range.empty,
                   want_range.last);
          $display("%0t:           actual   start %0d count %0d empty %0b last %0b",
                   $time, seen_range.start, seen_range.count, seen_range.empty,
                   seen_range.last);
          fail_count++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) apply_beat({s_tuser, s_tdata[IDX_W-1:0]});
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_beat) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (idle_on && pending_beats.size() != 0 && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 4);
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_beat.func;
        s_tdata <= {IN_PAD_W'(0), next_beat.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_gap <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_mark(input int idx);
    beat_t b;
    b.func = FUNC_MARK;
    b.idx = IDX_W'(idx);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic add_flush();
    beat_t b;
    b.func = FUNC_FLUSH;
    b.idx = IDX_W'($urandom_range(0, ENTRY_COUNT_DEF - 1));
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || s_tvalid || expected_ranges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= GAP_W'(value);
    do @(posedge clk); while (!cfg_ready);
    gap_limit = GAP_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // marks spread upward from a base (wrapping), then a flush, sometimes an extra flush
  task automatic add_burst();
    int marks;
    int base;
    int spread;
    marks = $urandom_range(0, 12);
    base = $urandom_range(0, ENTRY_COUNT_DEF - 1);
    case ($urandom_range(0, 3))
      0: spread = ENTRY_COUNT_DEF - 1;
      1: spread = 300;
      2: spread = 64;
      default: spread = 8;
    endcase
    repeat (marks) add_mark((base + $urandom_range(0, spread)) % ENTRY_COUNT_DEF);
    if ($urandom_range(0, 7) == 0) add_flush();
    add_flush();
  endtask

  task automatic fill_random(input int target, input bit with_comb);
    int first;
    int step;
    int idx;
    first = beats_queued;
    if (with_comb) begin
      // evenly spaced marks, at or just over the effective gap limit apart
      step = ((gap_limit < GAP_MIN) ? GAP_MIN : gap_limit) + $urandom_range(0, 2);
      for (idx = $urandom_range(0, 3); idx < ENTRY_COUNT_DEF; idx += step) add_mark(idx);
      add_flush();
    end
    while (beats_queued - first < target) add_burst();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed cases at the reset gap limit
    add_flush();
    add_mark(0);
    add_mark(ENTRY_COUNT_DEF - 1);
    add_flush();
    add_mark(10'h155);
    add_mark(10'h2aa);
    add_mark(10'h155);
    add_flush();
    add_flush();
    add_mark(7);
    add_mark(5);
    add_mark(6);
    add_flush();
    add_mark(100);
    add_mark(121);
    add_flush();
    add_mark(220);
    add_mark(200);
    add_flush();
    add_mark(512);
    add_flush();
    drain();

    idle_on = 1'b1;
    write_gap(0);
    fill_random(80, 1'b1);
    write_gap(GAP_W'(ENTRY_COUNT_DEF - 1));
    fill_random(70, 1'b0);
    idle_on = 1'b0;
    write_gap(19);
    fill_random(70, 1'b1);
    idle_on = 1'b1;
    write_gap(21);
    fill_random(80, 1'b1);
    write_gap($urandom_range(20, ENTRY_COUNT_DEF - 1));
    fill_random(80, 1'b0);
    idle_on = 1'b0;
    write_gap(20);
    fill_random(80, 1'b1);

    if (expected_ranges.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_ranges.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/drc_pkg.sv
hw/rtl/dirty_range_coalescer.sv
sim/dirty_range_coalescer_tb.sv
